@@ rtl/core/daf_pkg.sv @@
`timescale 1ns / 1ps

package daf_pkg;

	localparam int VALUE_W = 12;
	localparam int CHAR_W  = 7;

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
	localparam logic [CHAR_W-1:0] CH_CR    = 7'd13;
	localparam logic [CHAR_W-1:0] CH_LF    = 7'd10;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

	// BCD of one value plus its leading-blank marks
	typedef struct packed {
		logic [15:0] bcd;    // thousands, hundreds, tens, units
		logic [2:0]  blank;  // bit 2 thousands, bit 1 hundreds, bit 0 tens
	} daf_digits_t;

endpackage

@@ rtl/core/decimal_ascii_formatter.sv @@
`timescale 1ns / 1ps
// Prints a 12-bit value as six ASCII characters: three blank-padded digits,
// units digit, CR, LF (last_char set on LF).
// The value passes three double-dabble stages and the digit register before the
// first character is valid, then one character per cycle while out_ready is high.
// The next value's digits load as its LF is accepted, so lines print back to back.
// Reset (arst_n low) empties the pipeline and clears busy_q and pos_q.

module decimal_ascii_formatter import daf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  ascii_char,
	output logic               last_char
);

	localparam logic [2:0] POS_UNITS = 3'd3;
	localparam logic [2:0] POS_CR    = 3'd4;
	localparam logic [2:0] POS_LF    = 3'd5;

	logic        pipe_valid;
	logic        pipe_ready;
	daf_digits_t pipe_digits;

	daf_bcd_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (pipe_valid),
		.out_ready  (pipe_ready),
		.out_digits (pipe_digits)
	);

	logic        busy_q;
	logic [2:0]  pos_q;
	daf_digits_t digits_q;
	logic        word_done;
	logic [3:0]  nib;
	logic        blank;

	assign word_done  = out_valid && out_ready;
	assign pipe_ready = !busy_q || (word_done && pos_q == POS_LF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= 3'd0;
		end else if (pipe_ready) begin
			busy_q <= pipe_valid;
			pos_q  <= 3'd0;
		end else if (word_done) begin
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_ready && pipe_valid) begin
			digits_q <= pipe_digits;
		end
	end

	always_comb begin
		nib   = 4'd0;
		blank = 1'b0;
		case (pos_q)
			3'd0: begin
				nib   = digits_q.bcd[15:12];
				blank = digits_q.blank[2];
			end
			3'd1: begin
				nib   = digits_q.bcd[11:8];
				blank = digits_q.blank[1];
			end
			3'd2: begin
				nib   = digits_q.bcd[7:4];
				blank = digits_q.blank[0];
			end
			default: begin
				nib   = digits_q.bcd[3:0];
				blank = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (pos_q)
			POS_UNITS: ascii_char = CH_ZERO + {3'b000, digits_q.bcd[3:0]};
			POS_CR:    ascii_char = CH_CR;
			POS_LF:    ascii_char = CH_LF;
			default:   ascii_char = blank ? CH_SPACE : (CH_ZERO + {3'b000, nib});
		endcase
	end

	assign last_char = (pos_q == POS_LF);
	assign out_valid = busy_q;

endmodule

@@ rtl/core/daf_bcd_pipe.sv @@
`timescale 1ns / 1ps

module daf_bcd_pipe import daf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output daf_digits_t        out_digits
);

	// One shift-add-3 step of double dabble
	function automatic logic [15:0] dabble(input logic [15:0] bcd, input logic b);
		logic [15:0] t;
		t = bcd;
		for (int n = 0; n < 4; n++) begin
			if (t[4*n +: 4] >= 4'd5) begin
				t[4*n +: 4] = t[4*n +: 4] + 4'd3;
			end
		end
		return {t[14:0], b};
	endfunction

	function automatic logic [15:0] dabble4(input logic [15:0] bcd, input logic [3:0] bits);
		logic [15:0] t;
		t = bcd;
		for (int k = 3; k >= 0; k--) begin
			t = dabble(t, bits[k]);
		end
		return t;
	endfunction

	logic        valid_s1, valid_s2, valid_s3;
	logic [15:0] bcd_s1, bcd_s2, bcd_s3;
	logic [7:0]  bin_s1;
	logic [3:0]  bin_s2;
	logic [2:0]  blank_s1, blank_s2, blank_s3;
	logic        adv_s1, adv_s2, adv_s3;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			bcd_s1   <= dabble4(16'd0, value[11:8]);
			bin_s1   <= value[7:0];
			blank_s1 <= {value < 12'd1000, value < 12'd100, value < 12'd10};
		end
		if (adv_s2 && valid_s1) begin
			bcd_s2   <= dabble4(bcd_s1, bin_s1[7:4]);
			bin_s2   <= bin_s1[3:0];
			blank_s2 <= blank_s1;
		end
		if (adv_s3 && valid_s2) begin
			bcd_s3   <= dabble4(bcd_s2, bin_s2);
			blank_s3 <= blank_s2;
		end
	end

	assign out_valid        = valid_s3;
	assign out_digits.bcd   = bcd_s3;
	assign out_digits.blank = blank_s3;

endmodule

@@ sim/decimal_ascii_formatter_tb.sv @@
`timescale 1ns / 1ps

module decimal_ascii_formatter_tb;
	import daf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 22;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} line_char_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CHAR_W-1:0]  ascii_char;
	logic               last_char;

	line_char_t pending_chars[$];
	line_char_t want;
	int         errors = 0;
	int         cycles = 0;
	bit         quiet = 1'b0;
	int         stall_request = 0;
	int         stall_left = 0;

	decimal_ascii_formatter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Queue the six characters one value prints: blanked leading digits, units, CR, LF.
	function automatic void queue_line(input logic [VALUE_W-1:0] v);
		int         num;
		int         digits[4];
		line_char_t c;
		num = int'(v);
		digits[0] = num / 1000;
		digits[1] = (num % 1000) / 100;
		digits[2] = (num % 100) / 10;
		digits[3] = num % 10;
		for (int k = 0; k < 3; k++) begin
			c.last = 1'b0;
			if ((k == 0 && num < 1000) || (k == 1 && num < 100) || (k == 2 && num < 10)) begin
				c.code = CH_SPACE;
			end else begin
				c.code = CH_ZERO + CHAR_W'(digits[k]);
			end
			pending_chars.push_back(c);
		end
		c.code = CH_ZERO + CHAR_W'(digits[3]);
		c.last = 1'b0;
		pending_chars.push_back(c);
		c.code = CH_CR;
		pending_chars.push_back(c);
		c.code = CH_LF;
		c.last = 1'b1;
		pending_chars.push_back(c);
	endfunction

	// Receiver: check each accepted word, then pick ready for the next edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: word with nothing expected: char %0d last %0d",
					$time, ascii_char, last_char);
			end else begin
				want = pending_chars.pop_front();
				if (ascii_char !== want.code) begin
					errors++;
					$display("%0t: ascii_char expected %0d actual %0d",
						$time, want.code, ascii_char);
				end
				if (last_char !== want.last) begin
					errors++;
					$display("%0t: last_char expected %0d actual %0d",
						$time, want.last, last_char);
				end
			end
		end
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offer one value and hold it until taken; valid stays high for a back-to-back word.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			value <= VALUE_W'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (!in_ready);
		queue_line(v);
	endtask

	task automatic test_directed();
		logic [VALUE_W-1:0] vals[] = '{0, 1, 9, 10, 11, 99, 100, 101, 999, 1000, 1001,
			4095, 4000, 1009, 1010, 3070, 2730, 1365, 2048, 512, 64, 8};
		foreach (vals[i]) send_value(vals[i]);
	endtask

	task automatic test_random(input int count);
		logic [VALUE_W-1:0] v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(5))
				0: v = VALUE_W'($urandom_range(9));
				1: v = VALUE_W'($urandom_range(99, 10));
				2: v = VALUE_W'($urandom_range(1010, 990));
				default: v = VALUE_W'($urandom);
			endcase
			send_value(v);
		end
	endtask

	task automatic test_no_idle(input int count);
		quiet = 1'b1;
		test_random(count);
		quiet = 1'b0;
	endtask

	// Hold off the receiver long enough for the pipeline to fill and stall the input.
	task automatic test_backpressure(input int count);
		stall_request = 80;
		test_random(count);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(190);
		test_no_idle(80);
		test_backpressure(40);
		// Drop valid at the accepting edge so the last word is not taken twice.
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
